### rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Shared widths, constants and calendar helpers for the millisecond-to-date
// converter.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int ELAPSED_W  = 32;
    localparam int YEAR_W     = 14;
    localparam int YEAR_WORK_W = YEAR_W + 1;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 6;
    localparam int MS_W       = 10;
    localparam int DAYS_W     = 6;
    localparam int REM_W      = 10;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MS_PER_SEC   = 1000;
    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;
    localparam int LEAP_FACTOR  = 25;
    localparam int YEAR_LIMIT   = 10000;
    localparam int MONTH_FEB    = 2;
    localparam int MONTH_DEC    = 12;
    localparam int FEB_LEAP_LEN = 29;

    // Four serial divider stages follow each other, each fed by the registered quotient bits of the one before.
    localparam int DIV_CYCLES = ELAPSED_W + 4;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_YEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_MONTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_MINUTE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SECOND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COUNT  = 3'd6;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Length of a month 1..12; a leap February has one more day.
    function automatic logic [DAY_W-1:0] days_in_month(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [MONTH_W-1:0] idx;
        idx = month - 4'd1;
        if (month == MONTH_W'(MONTH_FEB) && leap) begin
            return DAY_W'(FEB_LEAP_LEN);
        end else if (month == '0 || month > MONTH_W'(MONTH_DEC)) begin
            return MONTH_LEN[0];
        end else begin
            return MONTH_LEN[idx];
        end
    endfunction

endpackage

### rtl/cal_bitdiv.sv
// ----------------------------------------------------------------------------
// cal_bitdiv
// One restoring divider stage: while enabled, takes one dividend bit per cycle,
// MSB first, and emits one quotient bit per cycle; the remainder is left in place.
// ----------------------------------------------------------------------------
module cal_bitdiv (
    input  logic                      aclk,
    input  logic                      clear,
    input  logic                      enable,
    input  logic                      bit_in,
    input  logic [cal_pkg::REM_W-1:0] divisor,
    output logic [cal_pkg::REM_W-1:0] rem_out,
    output logic                      q_out
);
    import cal_pkg::*;

    logic [REM_W-1:0] rem_reg;
    logic             q_reg;
    logic [REM_W:0]   trial;
    logic             fits;
    logic [REM_W:0]   diff;

    always_comb begin
        trial = {rem_reg, bit_in};
        fits  = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            rem_reg <= '0;
            q_reg   <= 1'b0;
        end else if (enable) begin
            rem_reg <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
            q_reg   <= fits;
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

### rtl/calendar_time_from_elapsed_ms.sv
// ----------------------------------------------------------------------------
// calendar_time_from_elapsed_ms
// Converts a free-running millisecond count into a Gregorian date and time
// relative to a configured base moment.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction runs through the bit-serial divider chain, a
//   fix-up step and one to three month steps, then waits until the output
//   register is free. Only one transaction is in flight (s_ready is high only
//   in idle); a finished result waits in the output register while the next transaction is taken.
// Reset: synchronous on aresetn low; base registers return to 2000-01-01
//   00:00:00 at count 0, the engine goes idle and the output empties.
// ----------------------------------------------------------------------------
module calendar_time_from_elapsed_ms (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [cal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cal_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cal_pkg::ELAPSED_W-1:0]  s_now_count,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cal_pkg::YEAR_W-1:0]     m_year,
    output logic [cal_pkg::MONTH_W-1:0]    m_month,
    output logic [cal_pkg::DAY_W-1:0]      m_day,
    output logic [cal_pkg::HOUR_W-1:0]     m_hour,
    output logic [cal_pkg::MINUTE_W-1:0]   m_minute,
    output logic [cal_pkg::SECOND_W-1:0]   m_second,
    output logic [cal_pkg::MS_W-1:0]       m_millisecond
);
    import cal_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_WALK,
        ST_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Base registers
    // ------------------------------------------------------------------
    logic [YEAR_W-1:0]    base_year_reg;
    logic [MONTH_W-1:0]   base_month_reg;
    logic [DAY_W-1:0]     base_day_reg;
    logic [HOUR_W-1:0]    base_hour_reg;
    logic [MINUTE_W-1:0]  base_minute_reg;
    logic [SECOND_W-1:0]  base_second_reg;
    logic [ELAPSED_W-1:0] base_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_year_reg   <= YEAR_W'(2000);
            base_month_reg  <= MONTH_W'(1);
            base_day_reg    <= DAY_W'(1);
            base_hour_reg   <= '0;
            base_minute_reg <= '0;
            base_second_reg <= '0;
            base_count_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BASE_YEAR:   base_year_reg   <= cfg_wdata[YEAR_W-1:0];
                REG_BASE_MONTH:  base_month_reg  <= cfg_wdata[MONTH_W-1:0];
                REG_BASE_DAY:    base_day_reg    <= cfg_wdata[DAY_W-1:0];
                REG_BASE_HOUR:   base_hour_reg   <= cfg_wdata[HOUR_W-1:0];
                REG_BASE_MINUTE: base_minute_reg <= cfg_wdata[MINUTE_W-1:0];
                REG_BASE_SECOND: base_second_reg <= cfg_wdata[SECOND_W-1:0];
                REG_BASE_COUNT:  base_count_reg  <= cfg_wdata[ELAPSED_W-1:0];
                default: begin
                    // Drop writes to unused indexes.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Engine registers
    // ------------------------------------------------------------------
    state_t               state_reg,      state_next;
    logic [CNT_W-1:0]     cnt_reg,        cnt_next;
    logic [ELAPSED_W-1:0] elapsed_sh_reg, elapsed_sh_next;
    logic [YEAR_W-1:0]    year_sh_reg,    year_sh_next;
    logic [DAYS_W-1:0]    days_sh_reg,    days_sh_next;
    logic [YEAR_WORK_W-1:0] year_reg,     year_next;
    logic [MONTH_W-1:0]   month_reg,      month_next;
    logic [DAY_W-1:0]     day_reg,        day_next;
    logic [DAYS_W-1:0]    days_reg,       days_next;
    logic                 leap_reg,       leap_next;
    logic [HOUR_W-1:0]    hour_reg,       hour_next;
    logic [MINUTE_W-1:0]  minute_reg,     minute_next;
    logic [SECOND_W-1:0]  second_reg,     second_next;

    logic                 m_valid_reg,    m_valid_next;
    logic [YEAR_W-1:0]    m_year_reg,     m_year_next;
    logic [MONTH_W-1:0]   m_month_reg,    m_month_next;
    logic [DAY_W-1:0]     m_day_reg,      m_day_next;
    logic [HOUR_W-1:0]    m_hour_reg,     m_hour_next;
    logic [MINUTE_W-1:0]  m_minute_reg,   m_minute_next;
    logic [SECOND_W-1:0]  m_second_reg,   m_second_next;
    logic [MS_W-1:0]      m_ms_reg,       m_ms_next;

    logic s_accept;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Divider chain: /1000, /60, /60, /24, each stage fed by the registered
    // quotient bits of the one before. A fifth stage takes the
    // base year mod 25 for the century test.
    // ------------------------------------------------------------------
    logic             en_ms, en_sec, en_min, en_hr, en_days, en_yr;
    logic [REM_W-1:0] rem_ms, rem_sec, rem_min, rem_hr, rem_yr;
    logic             q_ms, q_sec, q_min, q_hr, q_yr;
    logic             in_div;

    always_comb begin
        in_div  = (state_reg == ST_DIV);
        en_ms   = in_div && (cnt_reg <  CNT_W'(ELAPSED_W));
        en_sec  = in_div && (cnt_reg >= CNT_W'(1)) && (cnt_reg <= CNT_W'(ELAPSED_W));
        en_min  = in_div && (cnt_reg >= CNT_W'(2)) && (cnt_reg <= CNT_W'(ELAPSED_W + 1));
        en_hr   = in_div && (cnt_reg >= CNT_W'(3)) && (cnt_reg <= CNT_W'(ELAPSED_W + 2));
        en_days = in_div && (cnt_reg >= CNT_W'(4));
        en_yr   = in_div && (cnt_reg <  CNT_W'(YEAR_W));
    end

    cal_bitdiv u_div_ms (
        .aclk    (aclk),
        .clear   (s_accept),
        .enable  (en_ms),
        .bit_in  (elapsed_sh_reg[ELAPSED_W-1]),
        .divisor (REM_W'(MS_PER_SEC)),
        .rem_out (rem_ms),
        .q_out   (q_ms)
    );

    cal_bitdiv u_div_sec (
        .aclk    (aclk),
        .clear   (s_accept),
        .enable  (en_sec),
        .bit_in  (q_ms),
        .divisor (REM_W'(SEC_PER_MIN)),
        .rem_out (rem_sec),
        .q_out   (q_sec)
    );

    cal_bitdiv u_div_min (
        .aclk    (aclk),
        .clear   (s_accept),
        .enable  (en_min),
        .bit_in  (q_sec),
        .divisor (REM_W'(MIN_PER_HOUR)),
        .rem_out (rem_min),
        .q_out   (q_min)
    );

    cal_bitdiv u_div_hr (
        .aclk    (aclk),
        .clear   (s_accept),
        .enable  (en_hr),
        .bit_in  (q_min),
        .divisor (REM_W'(HOUR_PER_DAY)),
        .rem_out (rem_hr),
        .q_out   (q_hr)
    );

    cal_bitdiv u_div_yr (
        .aclk    (aclk),
        .clear   (s_accept),
        .enable  (en_yr),
        .bit_in  (year_sh_reg[YEAR_W-1]),
        .divisor (REM_W'(LEAP_FACTOR)),
        .rem_out (rem_yr),
        .q_out   (q_yr)
    );

    // ------------------------------------------------------------------
    // Fix-up: clamp the base fields, add remainders with carry, and test
    // the base year for leap. Base fields are all below their radix after
    // clamping, so each carry is at most one.
    // ------------------------------------------------------------------
    logic [SECOND_W-1:0] bs_c;
    logic [MINUTE_W-1:0] bm_c;
    logic [HOUR_W-1:0]   bh_c;
    logic [MONTH_W-1:0]  month_c;
    logic [DAY_W-1:0]    day_c;
    logic [DAY_W-1:0]    dim_base;
    logic [SECOND_W:0]   sec_sum;
    logic [MINUTE_W:0]   min_sum;
    logic [HOUR_W:0]     hr_sum;
    logic                c_sec, c_min, c_hr;
    logic                div4, div25, div16, leap_c;

    always_comb begin
        bs_c = (base_second_reg > SECOND_W'(SEC_PER_MIN - 1)) ?
               SECOND_W'(SEC_PER_MIN - 1) : base_second_reg;
        bm_c = (base_minute_reg > MINUTE_W'(MIN_PER_HOUR - 1)) ?
               MINUTE_W'(MIN_PER_HOUR - 1) : base_minute_reg;
        bh_c = (base_hour_reg > HOUR_W'(HOUR_PER_DAY - 1)) ?
               HOUR_W'(HOUR_PER_DAY - 1) : base_hour_reg;

        month_c = base_month_reg;
        if (month_c == '0) begin
            month_c = MONTH_W'(1);
        end
        if (month_c > MONTH_W'(MONTH_DEC)) begin
            month_c = MONTH_W'(MONTH_DEC);
        end

        // Leap: divisible by 4 and not by 100, or divisible by 400.
        div4   = (base_year_reg[1:0] == 2'b00);
        div16  = (base_year_reg[3:0] == 4'b0000);
        div25  = (rem_yr == '0);
        leap_c = (div4 && !div25) || (div16 && div25);

        dim_base = days_in_month(month_c, leap_c);
        day_c    = base_day_reg;
        if (day_c == '0) begin
            day_c = DAY_W'(1);
        end
        if (day_c > dim_base) begin
            day_c = dim_base;
        end

        sec_sum = {1'b0, bs_c} + {1'b0, rem_sec[SECOND_W-1:0]};
        c_sec   = sec_sum >= (SECOND_W + 1)'(SEC_PER_MIN);
        if (c_sec) begin
            sec_sum = sec_sum - (SECOND_W + 1)'(SEC_PER_MIN);
        end

        min_sum = {1'b0, bm_c} + {1'b0, rem_min[MINUTE_W-1:0]} + {{MINUTE_W{1'b0}}, c_sec};
        c_min   = min_sum >= (MINUTE_W + 1)'(MIN_PER_HOUR);
        if (c_min) begin
            min_sum = min_sum - (MINUTE_W + 1)'(MIN_PER_HOUR);
        end

        hr_sum = {1'b0, bh_c} + {1'b0, rem_hr[HOUR_W-1:0]} + {{HOUR_W{1'b0}}, c_min};
        c_hr   = hr_sum >= (HOUR_W + 1)'(HOUR_PER_DAY);
        if (c_hr) begin
            hr_sum = hr_sum - (HOUR_W + 1)'(HOUR_PER_DAY);
        end
    end

    // ------------------------------------------------------------------
    // Month walk: one month boundary per cycle. Fifty days at most remain,
    // so the walk never lands past the 19th of a February it enters from
    // a new year; the leap flag of the base year serves throughout.
    // ------------------------------------------------------------------
    logic [DAY_W-1:0]  dim_walk;
    logic [DAYS_W:0]   day_sum;
    logic              cross_month;
    logic [DAYS_W-1:0] to_next;

    always_comb begin
        dim_walk    = days_in_month(month_reg, leap_reg);
        day_sum     = {2'b00, day_reg} + {1'b0, days_reg};
        cross_month = day_sum > {2'b00, dim_walk};
        to_next     = {1'b0, dim_walk} - {1'b0, day_reg} + DAYS_W'(1);
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        elapsed_sh_next = elapsed_sh_reg;
        year_sh_next    = year_sh_reg;
        days_sh_next    = days_sh_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        days_next       = days_reg;
        leap_next       = leap_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;

        m_valid_next  = m_valid_reg;
        m_year_next   = m_year_reg;
        m_month_next  = m_month_reg;
        m_day_next    = m_day_reg;
        m_hour_next   = m_hour_reg;
        m_minute_next = m_minute_reg;
        m_second_next = m_second_reg;
        m_ms_next     = m_ms_reg;

        // Free the output register once the downstream side takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    elapsed_sh_next = s_now_count - base_count_reg;
                    year_sh_next    = base_year_reg;
                    days_sh_next    = '0;
                    cnt_next        = '0;
                    state_next      = ST_DIV;
                end
            end
            ST_DIV: begin
                if (en_ms) begin
                    elapsed_sh_next = {elapsed_sh_reg[ELAPSED_W-2:0], 1'b0};
                end
                if (en_yr) begin
                    year_sh_next = {year_sh_reg[YEAR_W-2:0], 1'b0};
                end
                if (en_days) begin
                    days_sh_next = {days_sh_reg[DAYS_W-2:0], q_hr};
                end
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1)) begin
                    state_next = ST_FIX;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FIX: begin
                second_next = sec_sum[SECOND_W-1:0];
                minute_next = min_sum[MINUTE_W-1:0];
                hour_next   = hr_sum[HOUR_W-1:0];
                days_next   = days_sh_reg + {{(DAYS_W - 1){1'b0}}, c_hr};
                year_next   = {1'b0, base_year_reg};
                month_next  = month_c;
                day_next    = day_c;
                leap_next   = leap_c;
                state_next  = ST_WALK;
            end
            ST_WALK: begin
                if (days_reg == '0) begin
                    state_next = ST_DONE;
                end else if (cross_month) begin
                    days_next = days_reg - to_next;
                    day_next  = DAY_W'(1);
                    if (month_reg == MONTH_W'(MONTH_DEC)) begin
                        month_next = MONTH_W'(1);
                        year_next  = year_reg + YEAR_WORK_W'(1);
                    end else begin
                        month_next = month_reg + MONTH_W'(1);
                    end
                end else begin
                    day_next   = day_sum[DAY_W-1:0];
                    days_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_year_next   = (year_reg > YEAR_WORK_W'(YEAR_LIMIT)) ?
                                    YEAR_W'(YEAR_LIMIT) : year_reg[YEAR_W-1:0];
                    m_month_next  = month_reg;
                    m_day_next    = day_reg;
                    m_hour_next   = hour_reg;
                    m_minute_next = minute_reg;
                    m_second_next = second_reg;
                    m_ms_next     = rem_ms;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg        <= cnt_next;
        elapsed_sh_reg <= elapsed_sh_next;
        year_sh_reg    <= year_sh_next;
        days_sh_reg    <= days_sh_next;
        year_reg       <= year_next;
        month_reg      <= month_next;
        day_reg        <= day_next;
        days_reg       <= days_next;
        leap_reg       <= leap_next;
        hour_reg       <= hour_next;
        minute_reg     <= minute_next;
        second_reg     <= second_next;
        m_year_reg     <= m_year_next;
        m_month_reg    <= m_month_next;
        m_day_reg      <= m_day_next;
        m_hour_reg     <= m_hour_next;
        m_minute_reg   <= m_minute_next;
        m_second_reg   <= m_second_next;
        m_ms_reg       <= m_ms_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_year        = m_year_reg;
    assign m_month       = m_month_reg;
    assign m_day         = m_day_reg;
    assign m_hour        = m_hour_reg;
    assign m_minute      = m_minute_reg;
    assign m_second      = m_second_reg;
    assign m_millisecond = m_ms_reg;

    // Quotient bits of the year stage are not needed; only its remainder.
    logic unused_q_yr;
    assign unused_q_yr = q_yr;

endmodule
